// ----- rtl/i2cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbb_pkg: shared types and constants for the I2C bit-level master
// Operation codes, beat layouts of both channels, configuration indexes.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  // Operation codes; IDLE is the sequencer's rest code
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_WAIT  = 3'd4,
    OP_IDLE  = 3'd7
  } op_e_t;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;
  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // Phase counts per command
  localparam logic [4:0] PHASES_START    = 5'd3;
  localparam logic [4:0] PHASES_STOP     = 5'd3;
  localparam logic [4:0] PHASES_WRITE    = 5'd25;
  localparam logic [4:0] PHASES_READ_ACK = 5'd28;
  localparam logic [4:0] PHASES_READ_NAK = 5'd27;
  localparam logic [4:0] PHASES_WAIT     = 5'd7;
  localparam logic [4:0] DATA_PHASES     = 5'd24;

  // Input beat: one clock tick of the pin sequencer
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_beat_t;

  // Result beat: state after the tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } out_beat_t;

endpackage

// ----- rtl/i2cbb_chan_if.sv -----
// ----------------------------------------------------------------------------
// i2cbb_chan_if: valid/ready channel
// Carries one payload beat per handshake; source drives valid and payload.
// ----------------------------------------------------------------------------
interface i2cbb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/i2cbb_seq.sv -----
// ----------------------------------------------------------------------------
// i2cbb_seq: pin sequencer state and per-tick next-state logic
// Holds configuration, command state and pins; advances one tick per beat.
// ----------------------------------------------------------------------------
module i2cbb_seq
  import i2cbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  input  in_beat_t              cmd,
  output out_beat_t             result
);

  // Configuration registers
  logic [15:0] phase_ticks;
  logic [7:0]  ack_timeout;

  // Sequencer state
  op_e_t       cur_op;
  logic [4:0]  phase_idx;
  logic [15:0] tick_cnt;
  logic [7:0]  shift_reg;
  logic [7:0]  poll_cnt;
  logic        scl;
  logic        sda;
  logic        ack_choice;
  logic        nack_flag;
  logic [7:0]  rx_hold;

  op_e_t       cur_op_next;
  logic [4:0]  phase_idx_next;
  logic [15:0] tick_cnt_next;
  logic [7:0]  shift_reg_next;
  logic [7:0]  poll_cnt_next;
  logic        scl_next;
  logic        sda_next;
  logic        ack_choice_next;
  logic        nack_flag_next;
  logic [7:0]  rx_hold_next;
  logic        done_next;

  logic        run;
  logic        hold_poll;
  logic [8:0]  poll_inc;
  logic [16:0] tick_inc;
  logic [15:0] limit;
  logic [4:0]  phase_total;
  logic [1:0]  sub;

  // p mod 3 for p below 24: quotient by reciprocal 11/32
  function automatic logic [1:0] mod3(input logic [4:0] p);
    logic [8:0] prod;
    logic [4:0] rem;
    prod = 9'(p) * 9'd11;
    rem  = p - (5'(prod[8:5]) * 5'd3);
    return rem[1:0];
  endfunction

  assign limit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks <= cfg_data[15:0];
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Next state for one tick
  always_comb begin
    cur_op_next     = cur_op;
    phase_idx_next  = phase_idx;
    tick_cnt_next   = tick_cnt;
    shift_reg_next  = shift_reg;
    poll_cnt_next   = poll_cnt;
    scl_next        = scl;
    sda_next        = sda;
    ack_choice_next = ack_choice;
    nack_flag_next  = nack_flag;
    rx_hold_next    = rx_hold;
    done_next       = 1'b0;
    run             = 1'b0;
    hold_poll       = 1'b0;
    poll_inc        = '0;
    tick_inc        = '0;
    phase_total     = PHASES_WAIT;
    sub             = '0;

    // command launch while idle; unknown codes are dropped
    if (cur_op == OP_IDLE) begin
      if (cmd.cmd_valid && (cmd.operation <= OP_WAIT)) begin
        cur_op_next    = op_e_t'(cmd.operation);
        phase_idx_next = '0;
        tick_cnt_next  = '0;
        poll_cnt_next  = '0;
        if (cur_op_next == OP_WRITE) shift_reg_next = cmd.tx_byte;
        if (cur_op_next == OP_READ) begin
          shift_reg_next  = '0;
          ack_choice_next = cmd.send_ack;
        end
        if (cur_op_next == OP_WAIT) nack_flag_next = 1'b0;
        run = 1'b1;
      end
    end else begin
      run = 1'b1;
    end

    if (run) begin
      // ack poll: low SDA jumps to final phase, too many highs to stop
      if (cur_op_next == OP_WAIT && phase_idx_next == 5'd2) begin
        if (!cmd.sda_in) begin
          phase_idx_next = 5'd6;
        end else begin
          poll_inc = {1'b0, poll_cnt_next} + 9'd1;
          if (poll_inc > {1'b0, ack_timeout}) begin
            nack_flag_next = 1'b1;
            phase_idx_next = 5'd3;
          end else begin
            poll_cnt_next = poll_inc[7:0];
            hold_poll     = 1'b1;
          end
        end
        if (!hold_poll) tick_cnt_next = '0;
      end

      if (!hold_poll) begin
        // pin change on the first tick of a phase
        if (tick_cnt_next == 16'd0) begin
          sub = mod3(phase_idx_next);
          unique case (cur_op_next)
            OP_START: begin
              if (phase_idx_next == 5'd0) begin
                sda_next = 1'b1;
                scl_next = 1'b1;
              end else if (phase_idx_next == 5'd1) begin
                sda_next = 1'b0;
              end else begin
                scl_next = 1'b0;
              end
            end
            OP_STOP: begin
              if (phase_idx_next == 5'd0) sda_next = 1'b0;
              else if (phase_idx_next == 5'd1) scl_next = 1'b1;
              else sda_next = 1'b1;
            end
            OP_WRITE: begin
              if (phase_idx_next >= DATA_PHASES) begin
                sda_next = 1'b1;
              end else if (sub == 2'd0) begin
                sda_next = shift_reg_next[7];
              end else if (sub == 2'd1) begin
                scl_next = 1'b1;
              end else begin
                scl_next       = 1'b0;
                shift_reg_next = {shift_reg_next[6:0], 1'b0};
              end
            end
            OP_READ: begin
              if (phase_idx_next < DATA_PHASES) begin
                if (sub == 2'd0) begin
                  shift_reg_next = {shift_reg_next[6:0], 1'b0};
                  sda_next       = 1'b1;
                end else if (sub == 2'd1) begin
                  scl_next = 1'b1;
                end else begin
                  shift_reg_next = {shift_reg_next[7:1], cmd.sda_in};
                  scl_next       = 1'b0;
                end
              end else if (ack_choice_next) begin
                if (phase_idx_next == 5'd24) sda_next = 1'b0;
                else if (phase_idx_next == 5'd25) scl_next = 1'b1;
                else if (phase_idx_next == 5'd26) scl_next = 1'b0;
                else sda_next = 1'b1;
              end else begin
                if (phase_idx_next == 5'd24) sda_next = 1'b1;
                else if (phase_idx_next == 5'd25) scl_next = 1'b1;
                else scl_next = 1'b0;
              end
            end
            default: begin
              // wait ack: release, clock high, poll, stop, clock low
              if (phase_idx_next == 5'd0) sda_next = 1'b1;
              else if (phase_idx_next == 5'd1) scl_next = 1'b1;
              else if (phase_idx_next == 5'd3) sda_next = 1'b0;
              else if (phase_idx_next == 5'd4) scl_next = 1'b1;
              else if (phase_idx_next == 5'd5) sda_next = 1'b1;
              else if (phase_idx_next == 5'd6) scl_next = 1'b0;
            end
          endcase
        end

        // phase timing
        unique case (cur_op_next)
          OP_START: phase_total = PHASES_START;
          OP_STOP:  phase_total = PHASES_STOP;
          OP_WRITE: phase_total = PHASES_WRITE;
          OP_READ:  phase_total = ack_choice_next ? PHASES_READ_ACK : PHASES_READ_NAK;
          default:  phase_total = PHASES_WAIT;
        endcase
        tick_inc = {1'b0, tick_cnt_next} + 17'd1;
        if (tick_inc >= {1'b0, limit}) begin
          tick_cnt_next  = '0;
          phase_idx_next = phase_idx_next + 5'd1;
          if (phase_idx_next >= phase_total) begin
            if (cur_op_next == OP_READ) rx_hold_next = shift_reg_next;
            cur_op_next    = OP_IDLE;
            phase_idx_next = '0;
            done_next      = 1'b1;
          end
        end else begin
          tick_cnt_next = tick_inc[15:0];
        end
      end
    end
  end

  // Result of this tick
  always_comb begin
    result.scl_out     = scl_next;
    result.sda_out     = sda_next;
    result.ready_res   = (cur_op_next == OP_IDLE);
    result.done_res    = done_next;
    result.rx_byte     = rx_hold_next;
    result.ack_missing = nack_flag_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_op     <= OP_IDLE;
      phase_idx  <= '0;
      tick_cnt   <= '0;
      shift_reg  <= '0;
      poll_cnt   <= '0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      ack_choice <= 1'b0;
      nack_flag  <= 1'b0;
      rx_hold    <= '0;
    end else if (step) begin
      cur_op     <= cur_op_next;
      phase_idx  <= phase_idx_next;
      tick_cnt   <= tick_cnt_next;
      shift_reg  <= shift_reg_next;
      poll_cnt   <= poll_cnt_next;
      scl        <= scl_next;
      sda        <= sda_next;
      ack_choice <= ack_choice_next;
      nack_flag  <= nack_flag_next;
      rx_hold    <= rx_hold_next;
    end
  end

endmodule

// ----- rtl/i2cbb_out_stage.sv -----
// ----------------------------------------------------------------------------
// i2cbb_out_stage: result register
// Holds one result beat; takes the next one in the cycle the current drains.
// ----------------------------------------------------------------------------
module i2cbb_out_stage
  import i2cbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  out_beat_t             result,
  output logic                  space,
  i2cbb_chan_if.source          out_chan
);

  logic      valid;
  out_beat_t data;

  // free when empty or emptying this cycle
  assign space = !valid || out_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_chan.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data <= result;
  end

  assign out_chan.valid   = valid;
  assign out_chan.payload = data;

endmodule

// ----- rtl/i2c_bit_bang_master_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_bang_master_unit: I2C bit-level master, one beat per clock tick
//
//   channel   dir   payload      handshake
//   in_chan   in    in_beat_t    valid/ready, one tick per beat
//   out_chan  out   out_beat_t   valid/ready, one result per input beat
//   cfg       in    idx/data     cfg_we, no stall
//
// One input beat per cycle unless stalled; its result is registered and
// shows in the cycle after acceptance. The tick logic sits between the
// state registers and the result register. in_chan.ready drops only
// while the result register is full and out_chan is stalled. Synchronous
// reset: pins high, idle, phase_ticks 100, ack_timeout 250.
// ----------------------------------------------------------------------------
module i2c_bit_bang_master_unit
  import i2cbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  i2cbb_chan_if.sink            in_chan,
  i2cbb_chan_if.source          out_chan
);

  logic      space;
  logic      step;
  in_beat_t  cmd;
  out_beat_t result;

  assign in_chan.ready = space;
  assign step          = in_chan.valid && space;
  assign cmd           = in_chan.payload;

  // tick sequencer
  i2cbb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .cmd       (cmd),
    .result    (result)
  );

  // result register
  i2cbb_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .result   (result),
    .space    (space),
    .out_chan (out_chan)
  );

endmodule
